@@ rtl/dwls_pkg.sv @@
package dwls_pkg;

   localparam int CAPACITY_DEF = 1024;
   localparam int ITEM_W       = 32;
   localparam int LEN_W        = 11;
   localparam int ACT_W        = 2;
   localparam int STAT_W       = 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_INS_FRONT = 2'd0,
      ACT_INS_BACK  = 2'd1,
      ACT_REM_BACK  = 2'd2,
      ACT_SEARCH    = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      FSM_IDLE   = 1'b0,
      FSM_SEARCH = 1'b1
   } fsm_state_type;

   // scan unit -> top: end of a search and its outcome
   typedef struct packed {
      logic done;
      logic found;
   } scan_stat_type;

endpackage

@@ rtl/deque_with_linear_search.sv @@
// Channel  Dir  Ports                        Beat contents (low bit up)
// req      in   req_tvalid/tready/tdata/tuser  tuser: action[1:0]; tdata: item[31:0]
// rsp      out  rsp_tvalid/tready/tdata/tuser  tuser: status[1:0], found[2];
//                                             tdata: length[10:0], zero pad to 16
//
// Inserts and remove-back finish in the accept cycle: one beat per cycle while
// rsp drains. A search walks the ring from the front through the single RAM
// read port and one comparator, one entry per cycle, and posts its rsp beat
// when the scan ends, at the first match or after the last entry.
// Synchronous active-high reset empties the deque; no RAM clearing pass.
// req_tready is low during a search and while an unaccepted rsp beat is held.
module deque_with_linear_search
   import dwls_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // item[31:0]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // length[10:0], zeros[15:11]
   output logic [2:0]  rsp_tuser    // status[1:0], found[2]
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   fsm_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  front_ff, front_in;
   logic [IDX_W-1:0]  back_ff,  back_in;
   logic [CNT_W-1:0]  cnt_ff,   cnt_in;

   // result holding register
   logic              rsp_vld_ff, rsp_vld_in;
   status_type        rsp_stat_ff, rsp_stat_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;

   logic              accept;
   action_type        act;
   logic [IDX_W-1:0]  front_prev, back_next, back_prev;
   logic              is_full, is_empty;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic              scan_start;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [ITEM_W-1:0] rd_data;
   scan_stat_type     scan_stat;

   assign act        = action_type'(req_tuser);
   assign req_tready = (state_ff == FSM_IDLE) && (!rsp_vld_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign front_prev = (front_ff == '0) ? LAST_IDX : front_ff - IDX_W'(1);
   assign back_prev  = (back_ff == '0) ? LAST_IDX : back_ff - IDX_W'(1);
   assign back_next  = (back_ff == LAST_IDX) ? '0 : back_ff + IDX_W'(1);
   assign is_full    = (cnt_ff == FULL_CNT);
   assign is_empty   = (cnt_ff == '0);

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      cnt_in       = cnt_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_found_in = rsp_found_ff;
      rsp_len_in   = rsp_len_ff;
      wr_en        = 1'b0;
      wr_addr      = back_ff;
      scan_start   = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               rsp_stat_in  = STAT_OK;
               rsp_found_in = 1'b0;
               case (act)
                  ACT_INS_FRONT: begin
                     if (is_full) begin
                        rsp_stat_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = front_prev;
                        front_in = front_prev;
                        cnt_in   = cnt_ff + CNT_W'(1);
                     end
                  end
                  ACT_INS_BACK: begin
                     if (is_full) begin
                        rsp_stat_in = STAT_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        back_in = back_next;
                        cnt_in  = cnt_ff + CNT_W'(1);
                     end
                  end
                  ACT_REM_BACK: begin
                     if (is_empty) begin
                        rsp_stat_in = STAT_EMPTY;
                     end else begin
                        back_in = back_prev;
                        cnt_in  = cnt_ff - CNT_W'(1);
                     end
                  end
                  ACT_SEARCH: begin
                     scan_start = 1'b1;
                     state_in   = FSM_SEARCH;
                  end
                  default: begin
                  end
               endcase
               // search results are posted when the scan ends
               if (act != ACT_SEARCH) begin
                  rsp_vld_in = 1'b1;
                  rsp_len_in = LEN_W'(cnt_in);
               end
            end
         end
         FSM_SEARCH: begin
            if (scan_stat.done) begin
               rsp_vld_in   = 1'b1;
               rsp_stat_in  = STAT_OK;
               rsp_found_in = scan_stat.found;
               rsp_len_in   = LEN_W'(cnt_ff);
               state_in     = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FSM_IDLE;
         front_ff   <= '0;
         back_ff    <= '0;
         cnt_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         front_ff   <= front_in;
         back_ff    <= back_in;
         cnt_ff     <= cnt_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_stat_ff  <= rsp_stat_in;
      rsp_found_ff <= rsp_found_in;
      rsp_len_ff   <= rsp_len_in;
   end

   dwls_ram #(
      .WIDTH(ITEM_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_tdata),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // scan walks from the front for cnt entries
   dwls_scan #(
      .CAPACITY(CAPACITY)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (scan_start),
      .start_idx(front_ff),
      .start_cnt(cnt_ff),
      .key      (req_tdata),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .stat     (scan_stat)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(16 - LEN_W){1'b0}}, rsp_len_ff};
   assign rsp_tuser  = {rsp_found_ff, rsp_stat_ff};

endmodule

@@ rtl/dwls_ram.sv @@
module dwls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/dwls_scan.sv @@
module dwls_scan
   import dwls_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int IDX_W = $clog2(CAPACITY),
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [IDX_W-1:0]  start_idx,
   input  logic [CNT_W-1:0]  start_cnt,
   input  logic [ITEM_W-1:0] key,
   output logic              rd_en,
   output logic [IDX_W-1:0]  rd_addr,
   input  logic [ITEM_W-1:0] rd_data,
   output scan_stat_type     stat
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   logic              busy_ff,   busy_in;
   logic [IDX_W-1:0]  ptr_ff,    ptr_in;
   logic [CNT_W-1:0]  left_ff,   left_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [ITEM_W-1:0] key_ff,    key_in;
   logic              hit;

   // one compare per cycle against the registered RAM output
   assign hit     = rd_vld_ff && (rd_data == key_ff);
   assign rd_en   = busy_ff && (left_ff != '0);
   assign rd_addr = ptr_ff;

   always_comb begin
      busy_in   = busy_ff;
      ptr_in    = ptr_ff;
      left_in   = left_ff;
      key_in    = key_ff;
      rd_vld_in = rd_en;
      stat.done  = busy_ff && (hit || ((left_ff == '0) && !rd_vld_ff));
      stat.found = hit;
      if (start) begin
         busy_in   = 1'b1;
         ptr_in    = start_idx;
         left_in   = start_cnt;
         key_in    = key;
         rd_vld_in = 1'b0;
      end else if (busy_ff) begin
         if (rd_en) begin
            ptr_in  = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + IDX_W'(1);
            left_in = left_ff - CNT_W'(1);
         end
         if (stat.done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      left_ff <= left_in;
      key_ff  <= key_in;
   end

endmodule

@@ rtl/dwls_chk.sv @@
module dwls_chk
   import dwls_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

   // held beat stays up until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped before accept");

   // found is only set on a successful search
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == STAT_OK)
      else $error("found with non-ok status");

   // full status only when the deque is at capacity
   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == STAT_FULL |-> rsp_tdata[LEN_W-1:0] == CAP_LEN)
      else $error("full status with length below capacity");

   // empty status only when nothing is held
   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == STAT_EMPTY |-> rsp_tdata[LEN_W-1:0] == '0)
      else $error("empty status with nonzero length");

   // a request cannot be taken while an untaken result is held
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !(req_tvalid && req_tready))
      else $error("request accepted while result stalled");

endmodule

bind deque_with_linear_search dwls_chk #(
   .CAPACITY(CAPACITY)
) u_dwls_chk (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
